[rtl/lsep_pkg.sv]
package lsep_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_HEADER_LEN = 2'd0;
	localparam logic [1:0] REG_MAGIC_LEN  = 2'd1;
	localparam logic [1:0] REG_MAGIC_WORD = 2'd2;

	// register reset values
	localparam logic [9:0]  HEADER_LEN_RST = 10'd54;
	localparam logic [3:0]  MAGIC_LEN_RST  = 4'd2;
	localparam logic [63:0] MAGIC_WORD_RST = 64'd10787;

	// result kinds
	localparam logic [1:0] KIND_EXT_CHAR  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
	localparam logic [1:0] KIND_MISMATCH  = 2'd2;
	localparam logic [1:0] KIND_EMPTY_END = 2'd3;

	// hidden byte width and magic character limit
	localparam int unsigned BYTE_BITS = 8;
	localparam logic [3:0]  MAGIC_MAX = 4'd8;

	typedef struct packed {
		logic [9:0]  header_len;
		logic [3:0]  magic_len;
		logic [63:0] magic_word;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last;
	} result_t;

endpackage

[rtl/lsep_cfg_regs.sv]
module lsep_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_wdata,
	output lsep_pkg::cfg_t    cfg
);
	import lsep_pkg::*;

	cfg_t cfg_q;

	// register file, writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_len <= HEADER_LEN_RST;
			cfg_q.magic_len  <= MAGIC_LEN_RST;
			cfg_q.magic_word <= MAGIC_WORD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER_LEN: cfg_q.header_len <= cfg_wdata[9:0];
				REG_MAGIC_LEN:  cfg_q.magic_len  <= cfg_wdata[3:0];
				REG_MAGIC_WORD: cfg_q.magic_word <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/lsep_parser.sv]
module lsep_parser #(
	parameter int unsigned SIZE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lsep_pkg::cfg_t      cfg,
	input  logic                accept,
	input  logic [7:0]          carrier_byte,
	input  logic                frame_start,
	output logic                res_valid,
	output lsep_pkg::result_t   res
);
	import lsep_pkg::*;

	localparam int unsigned CNT_W = $clog2(SIZE_BITS);

	localparam logic [2:0] PH_HEADER  = 3'd0;
	localparam logic [2:0] PH_MAGIC   = 3'd1;
	localparam logic [2:0] PH_EXT_LEN = 3'd2;
	localparam logic [2:0] PH_EXT     = 3'd3;
	localparam logic [2:0] PH_PAY_LEN = 3'd4;
	localparam logic [2:0] PH_PAY     = 3'd5;
	localparam logic [2:0] PH_IDLE    = 3'd6;

	logic [2:0]           phase_q, phase_d;
	logic [9:0]           skip_q, skip_d;
	logic [CNT_W-1:0]     bit_cnt_q, bit_cnt_d;
	logic [SIZE_BITS-1:0] shift_q, shift_d;
	logic [2:0]           magic_idx_q, magic_idx_d;
	logic [SIZE_BITS-1:0] remain_q, remain_d;

	// values after an optional file restart
	logic [2:0]           ph;
	logic [9:0]           skip;
	logic [CNT_W-1:0]     bcnt;
	logic [SIZE_BITS-1:0] shf;
	logic [2:0]           midx;
	logic [SIZE_BITS-1:0] rem;

	logic                 gather;
	logic                 size_ph;
	logic [CNT_W-1:0]     need_m1;
	logic [SIZE_BITS-1:0] shift_new;
	logic [SIZE_BITS-1:0] unit;
	logic [7:0]           hbyte;
	logic [7:0]           expect_byte;
	logic [3:0]           magic_cnt;
	logic [SIZE_BITS-1:0] rem_m1;

	// magic length clamped to one through eight
	always_comb begin
		if (cfg.magic_len == 4'd0) begin
			magic_cnt = 4'd1;
		end else if (cfg.magic_len > MAGIC_MAX) begin
			magic_cnt = MAGIC_MAX;
		end else begin
			magic_cnt = cfg.magic_len;
		end
	end

	// one parse step per accepted carrier byte
	always_comb begin
		ph   = frame_start ? PH_HEADER : phase_q;
		skip = frame_start ? '0 : skip_q;
		bcnt = frame_start ? '0 : bit_cnt_q;
		shf  = frame_start ? '0 : shift_q;
		midx = frame_start ? '0 : magic_idx_q;
		rem  = frame_start ? '0 : remain_q;

		phase_d     = ph;
		skip_d      = skip;
		bit_cnt_d   = bcnt;
		shift_d     = shf;
		magic_idx_d = midx;
		remain_d    = rem;
		res_valid   = 1'b0;
		res         = '{out_byte: 8'd0, kind: KIND_EXT_CHAR, last: 1'b0};
		gather      = 1'b0;

		// header skip, the byte that ends it already carries a bit
		if (ph == PH_HEADER) begin
			if (skip < cfg.header_len) begin
				skip_d = skip + 10'd1;
			end else begin
				ph     = PH_MAGIC;
				bcnt   = '0;
				shf    = '0;
				gather = 1'b1;
			end
		end else if (ph != PH_IDLE && ph <= PH_PAY) begin
			gather = 1'b1;
		end

		size_ph     = (ph == PH_EXT_LEN) || (ph == PH_PAY_LEN);
		need_m1     = size_ph ? CNT_W'(SIZE_BITS - 1) : CNT_W'(BYTE_BITS - 1);
		shift_new   = {shf[SIZE_BITS-2:0], carrier_byte[0]};
		hbyte       = shift_new[7:0];
		unit        = size_ph ? shift_new : SIZE_BITS'(hbyte);
		expect_byte = cfg.magic_word[{midx, 3'b000} +: 8];
		rem_m1      = rem - SIZE_BITS'(1);

		if (gather) begin
			phase_d = ph;
			if (bcnt != need_m1) begin
				bit_cnt_d = bcnt + CNT_W'(1);
				shift_d   = shift_new;
			end else begin
				bit_cnt_d = '0;
				shift_d   = '0;
				unique case (ph)
					PH_MAGIC: begin
						if (hbyte != expect_byte) begin
							phase_d   = PH_IDLE;
							res_valid = 1'b1;
							res       = '{out_byte: 8'd0, kind: KIND_MISMATCH, last: 1'b1};
						end else if ({1'b0, midx} + 4'd1 >= magic_cnt) begin
							magic_idx_d = '0;
							phase_d     = PH_EXT_LEN;
						end else begin
							magic_idx_d = midx + 3'd1;
						end
					end
					PH_EXT_LEN: begin
						remain_d = unit;
						phase_d  = (unit == '0) ? PH_PAY_LEN : PH_EXT;
					end
					PH_EXT: begin
						remain_d  = rem_m1;
						if (rem_m1 == '0) phase_d = PH_PAY_LEN;
						res_valid = 1'b1;
						res       = '{out_byte: hbyte, kind: KIND_EXT_CHAR, last: 1'b0};
					end
					PH_PAY_LEN: begin
						remain_d = unit;
						if (unit == '0) begin
							phase_d   = PH_IDLE;
							res_valid = 1'b1;
							res       = '{out_byte: 8'd0, kind: KIND_EMPTY_END, last: 1'b1};
						end else begin
							phase_d = PH_PAY;
						end
					end
					default: begin
						// payload byte, the final one closes the file
						if (rem <= SIZE_BITS'(1)) begin
							remain_d  = '0;
							phase_d   = PH_IDLE;
							res_valid = 1'b1;
							res       = '{out_byte: hbyte, kind: KIND_PAYLOAD, last: 1'b1};
						end else begin
							remain_d  = rem_m1;
							res_valid = 1'b1;
							res       = '{out_byte: hbyte, kind: KIND_PAYLOAD, last: 1'b0};
						end
					end
				endcase
			end
		end
	end

	// parse state, updated only on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			skip_q      <= '0;
			bit_cnt_q   <= '0;
			shift_q     <= '0;
			magic_idx_q <= '0;
			remain_q    <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			skip_q      <= skip_d;
			bit_cnt_q   <= bit_cnt_d;
			shift_q     <= shift_d;
			magic_idx_q <= magic_idx_d;
			remain_q    <= remain_d;
		end
	end

endmodule

[rtl/lsep_out_stage.sv]
module lsep_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  lsep_pkg::result_t   in_res,
	output logic                load_ok,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,
	output logic [1:0]          m_axis_tuser,
	output logic                m_axis_tlast
);
	import lsep_pkg::*;

	logic    valid_q;
	result_t res_q;

	// register can take a new request when empty or being drained
	assign load_ok = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ok) begin
			valid_q <= in_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_ok && in_valid) begin
			res_q <= in_res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = res_q.out_byte;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tlast  = res_q.last;

endmodule

[rtl/lsb_stego_payload_extractor_top.sv]
// Extracts a hidden file from the least significant bits of a carrier image
// streamed in one raw byte per request, frame start flagged in tuser. After
// header_len bytes are skipped, each byte gives one hidden bit, MSB first; the
// magic characters are checked, then the extension and payload lengths
// (SIZE_BITS wide) and bytes are decoded. Extension characters come out with
// kind 0, payload bytes with kind 1 (tlast on the final one), a magic
// mismatch as kind 2 and an empty payload as kind 3, both with tlast and zero
// data; after any of those the block drops input until the next frame start.
// One carrier byte is taken every cycle: the parse state is computed from each
// byte and registered, and a result register sits between it and the output, so
// input stalls only while a held result is not taken.
module lsb_stego_payload_extractor_top #(
	parameter int unsigned SIZE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	// carrier byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] carrier_byte
	input  logic        s_axis_tuser,   // [0] frame_start
	// decoded stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast
);
	import lsep_pkg::*;

	cfg_t    cfg;
	result_t res;
	logic    res_valid;
	logic    load_ok;
	logic    accept;

	assign s_axis_tready = load_ok;
	assign accept        = s_axis_tvalid && load_ok;

	// configuration registers
	lsep_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// hidden stream parser
	lsep_parser #(
		.SIZE_BITS (SIZE_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.accept       (accept),
		.carrier_byte (s_axis_tdata),
		.frame_start  (s_axis_tuser),
		.res_valid    (res_valid),
		.res          (res)
	);

	// result register
	lsep_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (accept && res_valid),
		.in_res        (res),
		.load_ok       (load_ok),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
